// ===== rtl/rws_pkg.sv =====
// Shared types, register indexes and phase codes of the remote-wake sequencer.
`default_nettype none
package rws_pkg;

  localparam int TIMER_BITS = 23;
  localparam int CFG_BITS   = 23;
  localparam int IDX_BITS   = 3;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [9:0]            MIN_REPORT_LEN = 10'd10;
  localparam logic [7:0]            DPAD_RELEASED  = 8'h08;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_WAKE_ENABLE     = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_SETTLE_TICKS    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_HOLD_TICKS      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_RELEASE_TICKS   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_TIMEOUT_TICKS   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_ATTEMPT_LIMIT   = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_WAKE_KEYCODE    = 3'd6;

  // action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_SUSPEND = 3'd1;
  localparam logic [2:0] ACT_RESUME  = 3'd2;
  localparam logic [2:0] ACT_CONNECT = 3'd3;
  localparam logic [2:0] ACT_REPORT  = 3'd4;

  // sequence phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ARMED     = 3'd1;
  localparam logic [2:0] PH_REQUESTED = 3'd2;
  localparam logic [2:0] PH_KEY_DOWN  = 3'd3;
  localparam logic [2:0] PH_KEY_UP    = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] dpad_buttons;
    logic [7:0] shoulder_buttons;
    logic [7:0] system_buttons;
    logic [9:0] report_length;
    logic       wake_granted;
    logic       endpoint_ready;
    logic       report_accepted;
  } in_item_t;

  typedef struct packed {
    logic       wake_signal;
    logic       force_wake;
    logic       send_report;
    logic [7:0] report_key;
    logic [2:0] sequence_state;
    logic       suspended_flag;
  } out_item_t;

  typedef struct packed {
    logic                  wake_enable;
    logic [CFG_BITS-1:0]   settle_ticks;
    logic [CFG_BITS-1:0]   hold_ticks;
    logic [CFG_BITS-1:0]   release_settle_ticks;
    logic [CFG_BITS-1:0]   request_timeout_ticks;
    logic [3:0]            key_attempt_limit;
    logic [7:0]            press_keycode;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/usb_remote_wake_sequencer.sv =====
// Top level of the USB remote-wake sequencer: input register, core, result register.
// One word per clock sustained while out_ready is high: an accepted word is held in
// the input register, is applied to the sequencer state when it moves on into the
// result register, and its result is then shown from the result register. The only
// loop is the state update in rws_core; input and result registers stall together
// when out_ready is low with a word in the result register, and in_ready stays high
// while the input register is empty. Configuration writes take effect at the next
// clock edge.
`default_nettype none
module usb_remote_wake_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire rws_pkg::in_item_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output rws_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rws_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [rws_pkg::CFG_BITS-1:0]  cfg_wdata
);

  rws_pkg::cfg_t      cfg;
  rws_pkg::in_item_t  item_r;
  rws_pkg::out_item_t result;
  rws_pkg::out_item_t res_r;
  logic               item_valid_r;
  logic               res_valid_r;
  logic               advance;

  // move the held word on whenever the result slot is free or being taken
  assign advance  = !res_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  rws_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rws_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (item_valid_r && advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= result;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  a_force_implies_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.force_wake) |->
      (out_data.wake_signal && out_data.suspended_flag &&
       out_data.sequence_state == rws_pkg::PH_REQUESTED))
    else $error("force-wake without wake request into requested phase");

  a_key_only_when_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.send_report) |-> (out_data.report_key == 8'd0))
    else $error("report key set with no report sent");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && res_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// ===== rtl/rws_cfg_regs.sv =====
// Configuration register file of the remote-wake sequencer.
`default_nettype none
module rws_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rws_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [rws_pkg::CFG_BITS-1:0]  cfg_wdata,
  output rws_pkg::cfg_t                      cfg
);

  rws_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_enable           <= 1'b1;
      cfg_r.settle_ticks          <= 23'd150000;
      cfg_r.hold_ticks            <= 23'd80000;
      cfg_r.release_settle_ticks  <= 23'd200000;
      cfg_r.request_timeout_ticks <= 23'd5000000;
      cfg_r.key_attempt_limit     <= 4'd2;
      cfg_r.press_keycode         <= 8'h6A;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rws_pkg::REG_WAKE_ENABLE:   cfg_r.wake_enable           <= cfg_wdata[0];
        rws_pkg::REG_SETTLE_TICKS:  cfg_r.settle_ticks          <= cfg_wdata;
        rws_pkg::REG_HOLD_TICKS:    cfg_r.hold_ticks            <= cfg_wdata;
        rws_pkg::REG_RELEASE_TICKS: cfg_r.release_settle_ticks  <= cfg_wdata;
        rws_pkg::REG_TIMEOUT_TICKS: cfg_r.request_timeout_ticks <= cfg_wdata;
        rws_pkg::REG_ATTEMPT_LIMIT: cfg_r.key_attempt_limit     <= cfg_wdata[3:0];
        rws_pkg::REG_WAKE_KEYCODE:  cfg_r.press_keycode         <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/rws_core.sv =====
// Sequencer state and the per-word state update of the remote-wake sequencer.
`default_nettype none
module rws_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire rws_pkg::in_item_t  item,
  input  wire rws_pkg::cfg_t      cfg,
  output rws_pkg::out_item_t      result
);

  logic [2:0]                     phase_r, phase_nxt;
  logic [rws_pkg::TIMER_BITS-1:0] ticks_r, ticks_nxt;
  logic [3:0]                     attempts_r, attempts_nxt;
  logic [7:0]                     last_dpad_r, last_dpad_nxt;
  logic [7:0]                     last_shoulder_r, last_shoulder_nxt;
  logic [7:0]                     last_system_r, last_system_nxt;
  logic                           asleep_r, asleep_nxt;
  logic                           resume_r, resume_nxt;

  logic [rws_pkg::TIMER_BITS-1:0] ticks_inc;
  logic [4:0]                     next_attempt;
  logic                           armable;
  logic                           can_send;
  logic                           changed;
  logic                           try_wake;
  logic                           wsig, fwake, sent;
  logic [7:0]                     key;

  always_comb begin
    ticks_inc    = (ticks_r == rws_pkg::TIMER_MAX) ? ticks_r : ticks_r + 1'b1;
    next_attempt = {1'b0, attempts_r} + 5'd1;
    armable      = (phase_r == rws_pkg::PH_IDLE) || (phase_r == rws_pkg::PH_DONE) ||
                   (phase_r == rws_pkg::PH_ARMED);
    can_send     = item.endpoint_ready && item.report_accepted;
    changed      = (item.dpad_buttons != last_dpad_r) ||
                   (item.shoulder_buttons != last_shoulder_r) ||
                   (item.system_buttons != last_system_r);

    phase_nxt         = phase_r;
    ticks_nxt         = ticks_r;
    attempts_nxt      = attempts_r;
    last_dpad_nxt     = last_dpad_r;
    last_shoulder_nxt = last_shoulder_r;
    last_system_nxt   = last_system_r;
    asleep_nxt        = asleep_r;
    resume_nxt        = resume_r;
    wsig              = 1'b0;
    fwake             = 1'b0;
    sent              = 1'b0;
    key               = 8'd0;
    try_wake          = 1'b0;

    unique case (item.action)
      rws_pkg::ACT_TICK: begin
        ticks_nxt = ticks_inc;
        unique case (phase_r)
          rws_pkg::PH_REQUESTED: begin
            if (resume_r || !asleep_r) begin
              resume_nxt = 1'b0;
              if (ticks_inc >= cfg.settle_ticks && can_send) begin
                sent      = 1'b1;
                key       = cfg.press_keycode;
                phase_nxt = rws_pkg::PH_KEY_DOWN;
                ticks_nxt = '0;
              end
            end else if (ticks_inc > cfg.request_timeout_ticks) begin
              phase_nxt = rws_pkg::PH_DONE;
              ticks_nxt = '0;
            end
          end
          rws_pkg::PH_KEY_DOWN: begin
            if (ticks_inc >= cfg.hold_ticks && can_send) begin
              sent      = 1'b1;
              phase_nxt = rws_pkg::PH_KEY_UP;
              ticks_nxt = '0;
            end
          end
          rws_pkg::PH_KEY_UP: begin
            if (ticks_inc >= cfg.release_settle_ticks) begin
              if (next_attempt < {1'b0, cfg.key_attempt_limit}) begin
                if (can_send) begin
                  sent         = 1'b1;
                  key          = cfg.press_keycode;
                  attempts_nxt = next_attempt[3:0];
                  phase_nxt    = rws_pkg::PH_KEY_DOWN;
                  ticks_nxt    = '0;
                end
              end else begin
                attempts_nxt = 4'd0;
                phase_nxt    = rws_pkg::PH_DONE;
                ticks_nxt    = '0;
              end
            end
          end
          default: ;
        endcase
      end
      rws_pkg::ACT_SUSPEND: begin
        asleep_nxt        = 1'b1;
        resume_nxt        = 1'b0;
        phase_nxt         = rws_pkg::PH_ARMED;
        ticks_nxt         = '0;
        last_dpad_nxt     = rws_pkg::DPAD_RELEASED;
        last_shoulder_nxt = 8'd0;
        last_system_nxt   = 8'd0;
        attempts_nxt      = 4'd0;
      end
      rws_pkg::ACT_RESUME: begin
        asleep_nxt = 1'b0;
        resume_nxt = 1'b1;
      end
      rws_pkg::ACT_CONNECT: begin
        try_wake = asleep_r && armable;
      end
      rws_pkg::ACT_REPORT: begin
        if (item.report_length >= rws_pkg::MIN_REPORT_LEN) begin
          last_dpad_nxt     = item.dpad_buttons;
          last_shoulder_nxt = item.shoulder_buttons;
          last_system_nxt   = item.system_buttons;
          try_wake          = changed && armable;
        end
      end
      default: ;
    endcase

    // a refused request while asleep falls back to force-wake
    if (try_wake && cfg.wake_enable) begin
      wsig = 1'b1;
      if (!item.wake_granted && asleep_r) begin
        fwake = 1'b1;
      end
      if (item.wake_granted || asleep_r) begin
        phase_nxt = rws_pkg::PH_REQUESTED;
        ticks_nxt = '0;
      end
    end

    result.wake_signal    = wsig;
    result.force_wake     = fwake;
    result.send_report    = sent;
    result.report_key     = key;
    result.sequence_state = phase_nxt;
    result.suspended_flag = asleep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= rws_pkg::PH_IDLE;
      ticks_r         <= '0;
      attempts_r      <= 4'd0;
      last_dpad_r     <= rws_pkg::DPAD_RELEASED;
      last_shoulder_r <= 8'd0;
      last_system_r   <= 8'd0;
      asleep_r        <= 1'b0;
      resume_r        <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      ticks_r         <= ticks_nxt;
      attempts_r      <= attempts_nxt;
      last_dpad_r     <= last_dpad_nxt;
      last_shoulder_r <= last_shoulder_nxt;
      last_system_r   <= last_system_nxt;
      asleep_r        <= asleep_nxt;
      resume_r        <= resume_nxt;
    end
  end

endmodule
`default_nettype wire
